// ===== hdl/wmmt_pkg.sv =====
// ----------------------------------------------------------------------------
// wmmt_pkg
// Shared widths, types, codes and states of the window min/max/mean tracker.
// ----------------------------------------------------------------------------
package wmmt_pkg;

    localparam int MAX_WINDOW  = 8;
    localparam int SAMPLE_BITS = 16;

    localparam int LEN_BITS    = 4;
    localparam int POS_BITS    = 3;
    localparam int COUNT_BITS  = 4;

    localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
    localparam int ADDR_W    = $clog2(MAX_WINDOW);
    // wide enough for the count, the length register and a position
    localparam int EXT_W     = (CNT_W > LEN_BITS) ? CNT_W : LEN_BITS;
    localparam int SUM_W     = SAMPLE_BITS + CNT_W;
    localparam int DIV_STEPS = (SUM_W + 1) / 2;
    localparam int DIV_W     = 2 * DIV_STEPS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic        [CNT_W-1:0]       t_count;
    typedef logic        [ADDR_W-1:0]      t_addr;
    typedef logic        [EXT_W-1:0]       t_ext;
    typedef logic signed [SUM_W-1:0]       t_sum;
    typedef logic        [SUM_W-1:0]       t_mag;
    typedef logic        [DIV_W-1:0]       t_div;
    typedef logic        [STEP_W-1:0]      t_step;
    typedef logic        [LEN_BITS-1:0]    t_len;
    typedef logic        [POS_BITS-1:0]    t_pos;
    typedef logic        [COUNT_BITS-1:0]  t_entry_count;

    localparam t_len WINDOW_LENGTH_RESET = t_len'(5);

    localparam logic MODE_APPEND  = 1'b0;
    localparam logic MODE_DISCARD = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_APPEND,
        ST_SCAN,
        ST_DIVIDE,
        ST_DONE
    } t_state;

endpackage

// ===== hdl/wmmt_in_if.sv =====
// ----------------------------------------------------------------------------
// wmmt_in_if
// Input item channel: valid/ready handshake with mode, sample and position.
// ----------------------------------------------------------------------------
interface wmmt_in_if;
    logic              valid;
    logic              ready;
    logic              mode;
    wmmt_pkg::t_sample sample;
    wmmt_pkg::t_pos    position;

    modport source (output valid, output mode, output sample, output position,
                    input ready);
    modport sink   (input valid, input mode, input sample, input position,
                    output ready);
endinterface

// ===== hdl/wmmt_out_if.sv =====
// ----------------------------------------------------------------------------
// wmmt_out_if
// Result channel: valid/ready handshake with count, statistics and error flag.
// ----------------------------------------------------------------------------
interface wmmt_out_if;
    logic                   valid;
    logic                   ready;
    wmmt_pkg::t_entry_count entry_count;
    logic                   stats_valid;
    wmmt_pkg::t_sample      mean_value;
    wmmt_pkg::t_sample      largest_value;
    wmmt_pkg::t_sample      smallest_value;
    logic                   bad_position;

    modport source (output valid, output entry_count, output stats_valid,
                    output mean_value, output largest_value, output smallest_value,
                    output bad_position, input ready);
    modport sink   (input valid, input entry_count, input stats_valid,
                    input mean_value, input largest_value, input smallest_value,
                    input bad_position, output ready);
endinterface

// ===== hdl/wmmt_cfg_if.sv =====
// ----------------------------------------------------------------------------
// wmmt_cfg_if
// Configuration write channel carrying the window length register.
// ----------------------------------------------------------------------------
interface wmmt_cfg_if;
    logic           valid;
    logic           ready;
    wmmt_pkg::t_len window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

// ===== hdl/wmmt_ram.sv =====
// ----------------------------------------------------------------------------
// wmmt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wmmt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/window_min_max_mean_tracker_top.sv =====
// Sequence: shift to close the gap or drop the oldest, append the new sample, scan,
//   divide (skipped when empty), load the output register; steps not needed are skipped.
// Throughput: one item at a time; the next is accepted once the result is in
//   the output register. Set by the single RAM read port walking the window and
//   the 2-bit-per-cycle divider.
// Reset: synchronous active-low; clears count and control, window length to 5.
// ----------------------------------------------------------------------------
// window_min_max_mean_tracker_top
// Sliding window of signed samples in a RAM; reports count, mean, max and min.
// ----------------------------------------------------------------------------
module window_min_max_mean_tracker_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wmmt_in_if.sink           i_in,
    wmmt_out_if.source        o_out,
    wmmt_cfg_if.sink          i_cfg
);

    wmmt_pkg::t_state  r_state, n_state;
    wmmt_pkg::t_len    r_window_length;
    wmmt_pkg::t_count  r_held, n_held;
    logic              r_mode, n_mode;
    wmmt_pkg::t_sample r_sample, n_sample;
    logic              r_bad, n_bad;
    wmmt_pkg::t_count  r_drop, n_drop;
    wmmt_pkg::t_count  r_rd_idx, n_rd_idx;
    wmmt_pkg::t_count  r_wr_idx, n_wr_idx;
    logic              r_rd_pend, n_rd_pend;
    wmmt_pkg::t_sum    r_sum, n_sum;
    wmmt_pkg::t_sample r_hi, n_hi;
    wmmt_pkg::t_sample r_lo, n_lo;
    logic              r_first, n_first;
    wmmt_pkg::t_div    r_mag, n_mag;
    wmmt_pkg::t_count  r_rem, n_rem;
    wmmt_pkg::t_div    r_quo, n_quo;
    logic              r_neg, n_neg;
    wmmt_pkg::t_step   r_step, n_step;

    logic                   r_out_valid, n_out_valid;
    wmmt_pkg::t_entry_count r_out_count, n_out_count;
    logic                   r_out_stats, n_out_stats;
    wmmt_pkg::t_sample      r_out_mean, n_out_mean;
    wmmt_pkg::t_sample      r_out_hi, n_out_hi;
    wmmt_pkg::t_sample      r_out_lo, n_out_lo;
    logic                   r_out_bad, n_out_bad;

    logic              in_xfer;
    logic              out_free;
    wmmt_pkg::t_ext    len_ext;
    wmmt_pkg::t_ext    eff_ext;
    wmmt_pkg::t_count  eff_len;
    wmmt_pkg::t_count  drop_cnt;
    logic              pos_ok;
    logic              rd_more;
    logic              start_scan;
    wmmt_pkg::t_sample rd_sample;
    wmmt_pkg::t_mag    sum_abs;

    logic [wmmt_pkg::CNT_W:0]   trial_a, trial_b, div_ext;
    logic                       qbit_a, qbit_b;
    wmmt_pkg::t_count           rem_a, rem_b;
    wmmt_pkg::t_div             quo_neg;

    logic                       ram_wr_en;
    wmmt_pkg::t_addr            ram_wr_addr;
    logic [wmmt_pkg::SAMPLE_BITS-1:0] ram_wr_data;
    logic                       ram_rd_en;
    wmmt_pkg::t_addr            ram_rd_addr;
    logic [wmmt_pkg::SAMPLE_BITS-1:0] ram_rd_data;

    wmmt_ram #(
        .WIDTH (wmmt_pkg::SAMPLE_BITS),
        .DEPTH (wmmt_pkg::MAX_WINDOW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Handshakes and helpers
    // ------------------------------------------------------------------
    assign i_in.ready  = (r_state == wmmt_pkg::ST_IDLE);
    assign in_xfer     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign out_free    = !r_out_valid || o_out.ready;

    // zero acts as one, anything above the store depth as the depth
    assign len_ext = wmmt_pkg::t_ext'(r_window_length);
    assign eff_ext = (len_ext == '0) ? wmmt_pkg::t_ext'(1) :
                     (len_ext > wmmt_pkg::t_ext'(wmmt_pkg::MAX_WINDOW)) ?
                     wmmt_pkg::t_ext'(wmmt_pkg::MAX_WINDOW) : len_ext;
    assign eff_len  = wmmt_pkg::t_count'(eff_ext);
    assign drop_cnt = (r_held >= eff_len) ? (r_held - eff_len + wmmt_pkg::t_count'(1)) : '0;
    assign pos_ok   = wmmt_pkg::t_ext'(i_in.position) < wmmt_pkg::t_ext'(r_held);

    assign rd_more   = r_rd_idx < r_held;
    assign rd_sample = wmmt_pkg::t_sample'(ram_rd_data);
    assign sum_abs   = r_sum[wmmt_pkg::SUM_W-1] ? wmmt_pkg::t_mag'(-r_sum)
                                                : wmmt_pkg::t_mag'(r_sum);

    // two restoring division steps per cycle; remainder stays below the count
    assign div_ext = {1'b0, r_held};
    assign trial_a = {r_rem, r_mag[wmmt_pkg::DIV_W-1]};
    assign qbit_a  = trial_a >= div_ext;
    assign rem_a   = qbit_a ? wmmt_pkg::t_count'(trial_a - div_ext)
                            : wmmt_pkg::t_count'(trial_a);
    assign trial_b = {rem_a, r_mag[wmmt_pkg::DIV_W-2]};
    assign qbit_b  = trial_b >= div_ext;
    assign rem_b   = qbit_b ? wmmt_pkg::t_count'(trial_b - div_ext)
                            : wmmt_pkg::t_count'(trial_b);
    assign quo_neg = r_neg ? (~r_quo + wmmt_pkg::t_div'(1)) : r_quo;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wmmt_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (i_in.mode == wmmt_pkg::MODE_APPEND) begin
                        n_state = (drop_cnt != '0) ? wmmt_pkg::ST_SHIFT
                                                   : wmmt_pkg::ST_APPEND;
                    end else begin
                        n_state = pos_ok ? wmmt_pkg::ST_SHIFT : wmmt_pkg::ST_SCAN;
                    end
                end
            end
            wmmt_pkg::ST_SHIFT: begin
                if (!rd_more && !r_rd_pend) begin
                    n_state = (r_mode == wmmt_pkg::MODE_APPEND) ? wmmt_pkg::ST_APPEND
                                                                : wmmt_pkg::ST_SCAN;
                end
            end
            wmmt_pkg::ST_APPEND: n_state = wmmt_pkg::ST_SCAN;
            wmmt_pkg::ST_SCAN: begin
                if (!rd_more && !r_rd_pend) begin
                    n_state = (r_held == '0) ? wmmt_pkg::ST_DONE : wmmt_pkg::ST_DIVIDE;
                end
            end
            wmmt_pkg::ST_DIVIDE: begin
                if (r_step == wmmt_pkg::t_step'(wmmt_pkg::DIV_STEPS - 1)) begin
                    n_state = wmmt_pkg::ST_DONE;
                end
            end
            wmmt_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = wmmt_pkg::ST_IDLE;
                end
            end
            default: n_state = wmmt_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and RAM control
    // ------------------------------------------------------------------
    always_comb begin
        n_held      = r_held;
        n_mode      = r_mode;
        n_sample    = r_sample;
        n_bad       = r_bad;
        n_drop      = r_drop;
        n_rd_idx    = r_rd_idx;
        n_wr_idx    = r_wr_idx;
        n_rd_pend   = 1'b0;
        n_sum       = r_sum;
        n_hi        = r_hi;
        n_lo        = r_lo;
        n_first     = r_first;
        n_mag       = r_mag;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_neg       = r_neg;
        n_step      = r_step;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_count = r_out_count;
        n_out_stats = r_out_stats;
        n_out_mean  = r_out_mean;
        n_out_hi    = r_out_hi;
        n_out_lo    = r_out_lo;
        n_out_bad   = r_out_bad;
        start_scan  = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_wr_idx[wmmt_pkg::ADDR_W-1:0];
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_rd_idx[wmmt_pkg::ADDR_W-1:0];

        unique case (r_state)
            wmmt_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_mode   = i_in.mode;
                    n_sample = i_in.sample;
                    n_bad    = 1'b0;
                    if (i_in.mode == wmmt_pkg::MODE_APPEND) begin
                        // drop the oldest entries so that the append leaves the window length held
                        n_drop   = drop_cnt;
                        n_wr_idx = '0;
                        n_rd_idx = drop_cnt;
                    end else if (pos_ok) begin
                        n_drop   = wmmt_pkg::t_count'(1);
                        n_wr_idx = wmmt_pkg::t_count'(i_in.position);
                        n_rd_idx = wmmt_pkg::t_count'(i_in.position)
                                   + wmmt_pkg::t_count'(1);
                    end else begin
                        n_bad      = 1'b1;
                        start_scan = 1'b1;
                    end
                end
            end
            wmmt_pkg::ST_SHIFT: begin
                // read ahead of the write pointer; the two never meet
                if (rd_more) begin
                    ram_rd_en = 1'b1;
                    n_rd_idx  = r_rd_idx + wmmt_pkg::t_count'(1);
                    n_rd_pend = 1'b1;
                end
                if (r_rd_pend) begin
                    ram_wr_en = 1'b1;
                    n_wr_idx  = r_wr_idx + wmmt_pkg::t_count'(1);
                end
                if (!rd_more && !r_rd_pend) begin
                    n_held = r_held - r_drop;
                    if (r_mode != wmmt_pkg::MODE_APPEND) begin
                        start_scan = 1'b1;
                    end
                end
            end
            wmmt_pkg::ST_APPEND: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_held[wmmt_pkg::ADDR_W-1:0];
                ram_wr_data = r_sample;
                n_held      = r_held + wmmt_pkg::t_count'(1);
                start_scan  = 1'b1;
            end
            wmmt_pkg::ST_SCAN: begin
                if (rd_more) begin
                    ram_rd_en = 1'b1;
                    n_rd_idx  = r_rd_idx + wmmt_pkg::t_count'(1);
                    n_rd_pend = 1'b1;
                end
                if (r_rd_pend) begin
                    n_sum   = r_sum + wmmt_pkg::t_sum'(rd_sample);
                    n_first = 1'b0;
                    if (r_first || (rd_sample > r_hi)) begin
                        n_hi = rd_sample;
                    end
                    if (r_first || (rd_sample < r_lo)) begin
                        n_lo = rd_sample;
                    end
                end
                if (!rd_more && !r_rd_pend) begin
                    n_mag  = wmmt_pkg::t_div'(sum_abs);
                    n_neg  = r_sum[wmmt_pkg::SUM_W-1];
                    n_rem  = '0;
                    n_quo  = '0;
                    n_step = '0;
                end
            end
            wmmt_pkg::ST_DIVIDE: begin
                n_rem  = rem_b;
                n_quo  = {r_quo[wmmt_pkg::DIV_W-3:0], qbit_a, qbit_b};
                n_mag  = {r_mag[wmmt_pkg::DIV_W-3:0], 2'b00};
                n_step = r_step + wmmt_pkg::t_step'(1);
            end
            wmmt_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_count = wmmt_pkg::t_entry_count'(r_held);
                    n_out_stats = (r_held != '0);
                    n_out_mean  = wmmt_pkg::t_sample'(quo_neg[wmmt_pkg::SAMPLE_BITS-1:0]);
                    n_out_hi    = r_hi;
                    n_out_lo    = r_lo;
                    n_out_bad   = r_bad;
                end
            end
            default: begin
                n_held = r_held;
            end
        endcase

        // empty window leaves zeros in every statistic
        if (start_scan) begin
            n_rd_idx  = '0;
            n_rd_pend = 1'b0;
            n_sum     = '0;
            n_hi      = '0;
            n_lo      = '0;
            n_first   = 1'b1;
            n_quo     = '0;
            n_neg     = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= wmmt_pkg::ST_IDLE;
            r_window_length <= wmmt_pkg::WINDOW_LENGTH_RESET;
            r_held          <= '0;
            r_rd_pend       <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_window_length <= i_cfg.window_length;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_sample    <= n_sample;
        r_bad       <= n_bad;
        r_drop      <= n_drop;
        r_rd_idx    <= n_rd_idx;
        r_wr_idx    <= n_wr_idx;
        r_sum       <= n_sum;
        r_hi        <= n_hi;
        r_lo        <= n_lo;
        r_first     <= n_first;
        r_mag       <= n_mag;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_neg       <= n_neg;
        r_step      <= n_step;
        r_out_count <= n_out_count;
        r_out_stats <= n_out_stats;
        r_out_mean  <= n_out_mean;
        r_out_hi    <= n_out_hi;
        r_out_lo    <= n_out_lo;
        r_out_bad   <= n_out_bad;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.entry_count    = r_out_count;
    assign o_out.stats_valid    = r_out_stats;
    assign o_out.mean_value     = r_out_mean;
    assign o_out.largest_value  = r_out_hi;
    assign o_out.smallest_value = r_out_lo;
    assign o_out.bad_position   = r_out_bad;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= wmmt_pkg::t_count'(wmmt_pkg::MAX_WINDOW))
        else $error("held count exceeds window depth");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state != wmmt_pkg::ST_IDLE))
        else $error("accepted transaction did not start processing");

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr_en |-> (r_state == wmmt_pkg::ST_SHIFT || r_state == wmmt_pkg::ST_APPEND))
        else $error("store written outside shift or append");

    a_shift_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr < ram_rd_addr))
        else $error("shift write overtook its read");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the window min/max/mean tracker against a cycle-free model of the
// window kept alongside it. Directed edge cases come first, then a sweep of
// window lengths and long random traffic. Random idle gaps are added on the
// input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        wmmt_pkg::t_entry_count entry_count;
        logic                   stats_valid;
        wmmt_pkg::t_sample      mean_value;
        wmmt_pkg::t_sample      largest_value;
        wmmt_pkg::t_sample      smallest_value;
        logic                   bad_position;
    } t_window_stats;

    logic clk;
    logic rst_n;

    wmmt_in_if  in_if ();
    wmmt_out_if out_if ();
    wmmt_cfg_if cfg_if ();

    window_min_max_mean_tracker_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // model of the window, updated at each accepted transaction
    wmmt_pkg::t_len    window_len_reg;
    wmmt_pkg::t_sample held_samples [wmmt_pkg::MAX_WINDOW];
    int                held_total;
    t_window_stats     pending_stats [$];

    int  mismatch_count  = 0;
    int  results_checked = 0;
    int  appends_sent    = 0;
    int  discards_sent   = 0;
    int  rejects_sent    = 0;
    int  length_writes   = 0;
    bit  steady_flow     = 1'b0;

    t_window_stats got_stats;
    t_window_stats want_stats;
    string         bad_fields;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #(64'd10_000_000);
        $display("timeout with %0d results still pending", pending_stats.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int idle_stretch();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic wmmt_pkg::t_sample random_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'sh8000;
        if (r == 1) return 16'sh7FFF;
        if (r == 2) return wmmt_pkg::t_sample'($urandom_range(0, 6) - 3);
        return wmmt_pkg::t_sample'($urandom);
    endfunction

    // remove one entry and close the gap
    function automatic void remove_entry(int pos);
        for (int k = pos; k + 1 < held_total; k++)
            held_samples[k] = held_samples[k + 1];
        held_total--;
    endfunction

    function automatic t_window_stats track_window_step(logic mode, wmmt_pkg::t_sample smp,
                                                        wmmt_pkg::t_pos pos);
        t_window_stats     r;
        int                len;
        longint            total;
        wmmt_pkg::t_sample hi;
        wmmt_pkg::t_sample lo;
        r = '0;
        if (mode == wmmt_pkg::MODE_APPEND) begin
            len = (window_len_reg == 0) ? 1 :
                  (window_len_reg > wmmt_pkg::MAX_WINDOW) ? wmmt_pkg::MAX_WINDOW :
                  int'(window_len_reg);
            while (held_total >= len && held_total > 0)
                remove_entry(0);
            if (held_total < wmmt_pkg::MAX_WINDOW) begin
                held_samples[held_total] = smp;
                held_total++;
            end
        end else if (int'(pos) < held_total) begin
            remove_entry(int'(pos));
        end else begin
            r.bad_position = 1'b1;
        end
        if (held_total > 0) begin
            total = 0;
            hi = held_samples[0];
            lo = held_samples[0];
            for (int k = 0; k < held_total; k++) begin
                total += longint'(held_samples[k]);
                if (held_samples[k] > hi) hi = held_samples[k];
                if (held_samples[k] < lo) lo = held_samples[k];
            end
            r.entry_count    = wmmt_pkg::t_entry_count'(held_total);
            r.stats_valid    = 1'b1;
            r.mean_value     = wmmt_pkg::t_sample'(total / longint'(held_total));
            r.largest_value  = hi;
            r.smallest_value = lo;
        end
        return r;
    endfunction

    // drive one item, hold it until accepted, then record its expected result
    task automatic send_item(logic mode, wmmt_pkg::t_sample smp, wmmt_pkg::t_pos pos);
        int            gap;
        t_window_stats step_stats;
        gap = idle_stretch();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid    <= 1'b1;
        in_if.mode     <= mode;
        in_if.sample   <= smp;
        in_if.position <= pos;
        do @(posedge clk); while (!in_if.ready);
        if (mode == wmmt_pkg::MODE_APPEND) appends_sent++;
        else if (int'(pos) < held_total) discards_sent++;
        else rejects_sent++;
        step_stats = track_window_step(mode, smp, pos);
        pending_stats.insert(pending_stats.size(), step_stats);
    endtask

    task automatic send_random_item(int append_pct);
        wmmt_pkg::t_pos pos;
        if ($urandom_range(0, 99) < append_pct) begin
            send_item(wmmt_pkg::MODE_APPEND, random_sample(), wmmt_pkg::t_pos'($urandom));
        end else begin
            if (held_total > 0 && $urandom_range(0, 99) < 75)
                pos = wmmt_pkg::t_pos'($urandom_range(0, held_total - 1));
            else
                pos = wmmt_pkg::t_pos'($urandom_range(0, 7));
            send_item(wmmt_pkg::MODE_DISCARD, wmmt_pkg::t_sample'($urandom), pos);
        end
    endtask

    // drop valid and wait for every pending result
    task automatic hold_input();
        in_if.valid <= 1'b0;
        do @(posedge clk); while (pending_stats.size() != 0);
    endtask

    task automatic set_window_length(wmmt_pkg::t_len value);
        hold_input();
        cfg_if.valid         <= 1'b1;
        cfg_if.window_length <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid   <= 1'b0;
        window_len_reg  = value;
        length_writes++;
    endtask

    task automatic test_directed_edges();
        send_item(wmmt_pkg::MODE_DISCARD, 16'sh0000, 3'd0);     // discard on empty window
        send_item(wmmt_pkg::MODE_DISCARD, 16'sh7FFF, 3'd7);
        send_item(wmmt_pkg::MODE_APPEND, 16'sh7FFF, 3'd7);
        send_item(wmmt_pkg::MODE_APPEND, 16'sh8000, 3'd0);
        send_item(wmmt_pkg::MODE_APPEND, -16'sd1, 3'd0);
        send_item(wmmt_pkg::MODE_APPEND, -16'sd2, 3'd0);
        send_item(wmmt_pkg::MODE_APPEND, 16'sd1, 3'd0);
        send_item(wmmt_pkg::MODE_APPEND, 16'sd0, 3'd5);  // full at reset length, oldest goes
        send_item(wmmt_pkg::MODE_DISCARD, 16'sh7FFF, 3'd5);     // position equal to count
        send_item(wmmt_pkg::MODE_DISCARD, 16'sh0000, 3'd4);     // youngest
        send_item(wmmt_pkg::MODE_DISCARD, 16'sh0000, 3'd0);     // oldest
        send_item(wmmt_pkg::MODE_DISCARD, 16'sh0000, 3'd1);     // middle
        send_item(wmmt_pkg::MODE_APPEND, -16'sd7, 3'd0);
        send_item(wmmt_pkg::MODE_APPEND, -16'sd6, 3'd0);
        while (held_total > 0)
            send_item(wmmt_pkg::MODE_DISCARD, 16'sh0000, 3'd0);
        send_item(wmmt_pkg::MODE_DISCARD, 16'sh0000, 3'd0);
        send_item(wmmt_pkg::MODE_APPEND, -16'sd7, 3'd0);        // truncation toward zero
        send_item(wmmt_pkg::MODE_APPEND, -16'sd6, 3'd0);
        send_item(wmmt_pkg::MODE_APPEND, 16'sd3, 3'd0);
    endtask

    task automatic test_length_lowered();
        set_window_length(wmmt_pkg::t_len'(wmmt_pkg::MAX_WINDOW));
        repeat (wmmt_pkg::MAX_WINDOW) send_item(wmmt_pkg::MODE_APPEND, random_sample(), 3'd0);
        set_window_length(wmmt_pkg::t_len'(2));                 // nothing dropped yet
        send_item(wmmt_pkg::MODE_DISCARD, 16'sh0000,
                  wmmt_pkg::t_pos'($urandom_range(0, wmmt_pkg::MAX_WINDOW - 1)));
        send_item(wmmt_pkg::MODE_APPEND, random_sample(), 3'd0);
        set_window_length(wmmt_pkg::t_len'(15));                // acts as the maximum
        repeat (wmmt_pkg::MAX_WINDOW + 2)
            send_item(wmmt_pkg::MODE_APPEND, random_sample(), 3'd0);
        send_item(wmmt_pkg::MODE_DISCARD, 16'sh0000, 3'd7);
        set_window_length(wmmt_pkg::t_len'(0));                 // acts as one
        repeat (3) send_item(wmmt_pkg::MODE_APPEND, random_sample(), 3'd0);
        send_item(wmmt_pkg::MODE_DISCARD, 16'sh0000, 3'd1);
        send_item(wmmt_pkg::MODE_DISCARD, 16'sh0000, 3'd0);
    endtask

    task automatic test_length_sweep();
        wmmt_pkg::t_len lengths [8] = '{1, 8, 0, 15, 9, 3, 6, 2};
        foreach (lengths[i]) begin
            set_window_length(lengths[i]);
            steady_flow = (i % 3 == 1);
            repeat (45) send_random_item(70);
        end
        steady_flow = 1'b0;
    endtask

    task automatic test_drain_pause();
        set_window_length(wmmt_pkg::t_len'(4));
        repeat (4) begin
            repeat (15) send_random_item(65);
            hold_input();
        end
    endtask

    task automatic test_random_traffic();
        repeat (5) begin
            set_window_length(wmmt_pkg::t_len'($urandom_range(0, 15)));
            steady_flow = ($urandom_range(0, 3) == 0);
            repeat (100) send_random_item($urandom_range(50, 85));
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        rst_n                <= 1'b0;
        in_if.valid          <= 1'b0;
        in_if.mode           <= wmmt_pkg::MODE_APPEND;
        in_if.sample         <= '0;
        in_if.position       <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.window_length <= wmmt_pkg::WINDOW_LENGTH_RESET;
        window_len_reg        = wmmt_pkg::WINDOW_LENGTH_RESET;
        held_total            = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_edges();
        test_length_lowered();
        test_length_sweep();
        test_drain_pause();
        test_random_traffic();

        hold_input();
        repeat (40) @(posedge clk);
        $display("covered %0d appends, %0d discards, %0d rejected discards, %0d length writes",
                 appends_sent, discards_sent, rejects_sent, length_writes);
        $display("%0d results checked, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // result side: random stalls
    initial begin
        int stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                stall_left = idle_stretch();
            end
        end
    end

    task automatic report_mismatch(string why);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t mismatch (%s)", $realtime, why);
            $display("  want cnt=%0d vld=%0d mean=%0d max=%0d min=%0d bad=%0d",
                     want_stats.entry_count, want_stats.stats_valid, want_stats.mean_value,
                     want_stats.largest_value, want_stats.smallest_value,
                     want_stats.bad_position);
            $display("  got  cnt=%0d vld=%0d mean=%0d max=%0d min=%0d bad=%0d",
                     got_stats.entry_count, got_stats.stats_valid, got_stats.mean_value,
                     got_stats.largest_value, got_stats.smallest_value,
                     got_stats.bad_position);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            got_stats = {out_if.entry_count, out_if.stats_valid, out_if.mean_value,
                         out_if.largest_value, out_if.smallest_value, out_if.bad_position};
            results_checked++;
            if (pending_stats.size() == 0) begin
                want_stats = '0;
                report_mismatch("result with nothing pending");
            end else begin
                want_stats = pending_stats.pop_front();
                bad_fields = "";
                if (got_stats.entry_count !== want_stats.entry_count)
                    bad_fields = {bad_fields, " entry_count"};
                if (got_stats.stats_valid !== want_stats.stats_valid)
                    bad_fields = {bad_fields, " stats_valid"};
                if (got_stats.mean_value !== want_stats.mean_value)
                    bad_fields = {bad_fields, " mean_value"};
                if (got_stats.largest_value !== want_stats.largest_value)
                    bad_fields = {bad_fields, " largest_value"};
                if (got_stats.smallest_value !== want_stats.smallest_value)
                    bad_fields = {bad_fields, " smallest_value"};
                if (got_stats.bad_position !== want_stats.bad_position)
                    bad_fields = {bad_fields, " bad_position"};
                if (bad_fields != "")
                    report_mismatch({"wrong", bad_fields});
            end
        end
    end

endmodule
